[rtl/mas_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_pkg
// shared constants and codes of the minimum arborescence solver
// ----------------------------------------------------------------------------
package mas_pkg;

    localparam int MAS_MAX_NODES   = 64;
    localparam int MAS_MAX_EDGES   = 1024;
    localparam int MAS_WEIGHT_BITS = 24;

    localparam int NODE_PORT_W = 7;
    localparam int EDGE_W_PORT = 24;
    localparam int COST_W      = 40;
    localparam int STATUS_W    = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_IN    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic CFG_NODE_COUNT = 1'b0;
    localparam logic CFG_ROOT_NODE  = 1'b1;

endpackage

[rtl/min_arborescence_solver_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_arborescence_solver_unit
// edge store plus a sequencer that runs the cycle contraction loop for the
// minimum arborescence and reports its total cost
// ----------------------------------------------------------------------------
// channel   direction  handshake               payload
// edge      in         i_start & !o_busy       i_edge_source/target/weight, i_last_edge
// result    out        o_valid, one cycle      o_total_cost, o_status
// config    in         i_cfg_we                i_cfg_index, i_cfg_data
//
// an edge item without the last mark is taken and leaves the block idle
// the last item starts the solve: a filter pass over the edges, then rounds of
// cycle contraction, bounded in number by the node count, each step paced by
// the single read port of the edge and node memories
// synchronous active-low reset; edge store needs no clearing pass
// the result strobe cannot be held off by the receiver
// ----------------------------------------------------------------------------
module min_arborescence_solver_unit
    import mas_pkg::*;
#(
    parameter int MAX_NODES   = MAS_MAX_NODES,
    parameter int MAX_EDGES   = MAS_MAX_EDGES,
    parameter int WEIGHT_BITS = MAS_WEIGHT_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [NODE_PORT_W-1:0] i_edge_source,
    input  logic [NODE_PORT_W-1:0] i_edge_target,
    input  logic [EDGE_W_PORT-1:0] i_edge_weight,
    input  logic                   i_last_edge,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [NODE_PORT_W-1:0] i_cfg_data,
    output logic                   o_valid,
    output logic [COST_W-1:0]      o_total_cost,
    output logic [STATUS_W-1:0]    o_status
);

    localparam int NB = $clog2(MAX_NODES + 1);
    localparam int NW = (NB > NODE_PORT_W) ? NB : NODE_PORT_W;
    localparam int EB = $clog2(MAX_EDGES);
    localparam int CB = $clog2(MAX_EDGES + 1);
    localparam int WW = WEIGHT_BITS;
    localparam int NS = 28;

    typedef enum logic [NS-1:0] {
        S_IDLE    = NS'(1) << 0,
        S_SETUP   = NS'(1) << 1,
        S_F_RD    = NS'(1) << 2,
        S_F_CHK   = NS'(1) << 3,
        S_F_CP_RD = NS'(1) << 4,
        S_F_CP_WR = NS'(1) << 5,
        S_I_CLR   = NS'(1) << 6,
        S_S_RD    = NS'(1) << 7,
        S_S_CHK   = NS'(1) << 8,
        S_S_CMP   = NS'(1) << 9,
        S_C_RD    = NS'(1) << 10,
        S_C_CHK   = NS'(1) << 11,
        S_R_FIX   = NS'(1) << 12,
        S_W_RD    = NS'(1) << 13,
        S_W_CHK   = NS'(1) << 14,
        S_L_CHK   = NS'(1) << 15,
        S_L_NXT   = NS'(1) << 16,
        S_G_RD    = NS'(1) << 17,
        S_G_CHK   = NS'(1) << 18,
        S_K_RD    = NS'(1) << 19,
        S_K_T     = NS'(1) << 20,
        S_K_H     = NS'(1) << 21,
        S_K_DO    = NS'(1) << 22,
        S_K_CP_RD = NS'(1) << 23,
        S_K_CP_WR = NS'(1) << 24,
        S_K_ROOT  = NS'(1) << 25,
        S_K_ROOT2 = NS'(1) << 26,
        S_DONE    = NS'(1) << 27
    } t_state;

    // configuration
    logic [NODE_PORT_W-1:0] r_node_count;
    logic [NODE_PORT_W-1:0] r_root_node;

    // memories
    logic [NW-1:0] tail_mem [MAX_EDGES];
    logic [NW-1:0] head_mem [MAX_EDGES];
    logic [WW-1:0] cost_mem [MAX_EDGES];
    logic [WW-1:0] cheap_mem [MAX_NODES+1];
    logic          has_mem   [MAX_NODES+1];
    logic [NB-1:0] pred_mem  [MAX_NODES+1];
    logic [NB-1:0] grp_mem   [MAX_NODES+1];
    logic [NB-1:0] mark_mem  [MAX_NODES+1];

    logic [NW-1:0] r_tail_q, r_head_q;
    logic [WW-1:0] r_cost_q, r_cheap_q;
    logic          r_has_q;
    logic [NB-1:0] r_pred_q, r_grp_q, r_mark_q;

    // sequencer state
    t_state        r_state, n_state;
    logic [NB-1:0] r_n, n_n, r_root, n_root, r_i, n_i, r_v, n_v, r_u, n_u;
    logic [NB-1:0] r_tn, n_tn, r_t, n_t, r_h, n_h, r_gu, n_gu;
    logic [CB-1:0] r_m, n_m, r_ei, n_ei, r_etotal, n_etotal;
    logic [WW-1:0] r_c, n_c;
    logic          r_first, n_first, r_ovf, n_ovf;
    logic [COST_W-1:0]   r_run, n_run, r_out_cost, n_out_cost;
    logic [STATUS_W-1:0] r_status, n_status, r_out_status, n_out_status;
    logic          r_out_valid, n_out_valid;

    // memory controls
    logic          e_we;
    logic [EB-1:0] e_waddr, e_raddr;
    logic [NW-1:0] e_wtail, e_whead;
    logic [WW-1:0] e_wcost;
    logic [NB-1:0] nd_raddr, nd_waddr;
    logic          we_cheap, we_has, we_pred, we_grp, we_mark;
    logic [WW-1:0] wd_cheap;
    logic          wd_has;
    logic [NB-1:0] wd_pred, wd_grp, wd_mark;

    // solve setup helpers
    logic [NW-1:0] nc_ext, n_clamp, root_ext;
    logic          bad_edge, walk_on;

    assign o_busy       = (r_state != S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_total_cost = r_out_cost;
    assign o_status     = r_out_status;

    always_comb begin
        nc_ext   = NW'(r_node_count);
        root_ext = NW'(r_root_node);
        if (nc_ext == '0) begin
            n_clamp = NW'(1);
        end else if (nc_ext > NW'(MAX_NODES)) begin
            n_clamp = NW'(MAX_NODES);
        end else begin
            n_clamp = nc_ext;
        end
        bad_edge = (r_tail_q == '0) || (r_tail_q > NW'(r_n)) ||
                   (r_head_q == '0) || (r_head_q > NW'(r_n));
        walk_on  = (r_mark_q != r_i) && (r_grp_q == '0) && (r_v != r_root);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_PORT_W'(64);
            r_root_node  <= NODE_PORT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_NODE_COUNT: r_node_count <= i_cfg_data;
                CFG_ROOT_NODE:  r_root_node  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state      = r_state;
        n_n          = r_n;
        n_root       = r_root;
        n_i          = r_i;
        n_v          = r_v;
        n_u          = r_u;
        n_tn         = r_tn;
        n_t          = r_t;
        n_h          = r_h;
        n_gu         = r_gu;
        n_m          = r_m;
        n_ei         = r_ei;
        n_etotal     = r_etotal;
        n_c          = r_c;
        n_first      = r_first;
        n_ovf        = r_ovf;
        n_run        = r_run;
        n_status     = r_status;
        n_out_valid  = 1'b0;
        n_out_cost   = r_out_cost;
        n_out_status = r_out_status;

        e_we     = 1'b0;
        e_waddr  = r_ei[EB-1:0];
        e_raddr  = r_ei[EB-1:0];
        e_wtail  = r_tail_q;
        e_whead  = r_head_q;
        e_wcost  = r_cost_q;
        nd_raddr = r_i;
        nd_waddr = r_i;
        we_cheap = 1'b0;
        we_has   = 1'b0;
        we_pred  = 1'b0;
        we_grp   = 1'b0;
        we_mark  = 1'b0;
        wd_cheap = '0;
        wd_has   = 1'b0;
        wd_pred  = '0;
        wd_grp   = '0;
        wd_mark  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_edge_source != i_edge_target) begin
                        if (r_etotal >= CB'(MAX_EDGES)) begin
                            n_ovf = 1'b1;
                        end else begin
                            e_we     = 1'b1;
                            e_waddr  = r_etotal[EB-1:0];
                            e_wtail  = NW'(i_edge_source);
                            e_whead  = NW'(i_edge_target);
                            e_wcost  = WW'(i_edge_weight);
                            n_etotal = r_etotal + CB'(1);
                        end
                    end
                    if (i_last_edge) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                n_run = '0;
                n_n   = NB'(n_clamp);
                n_root = NB'(root_ext);
                n_m   = r_etotal;
                n_ei  = '0;
                if (r_ovf) begin
                    n_status = ST_OVERFLOW;
                    n_state  = S_DONE;
                end else if (root_ext == '0 || root_ext > n_clamp) begin
                    n_status = ST_NO_IN;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_F_RD;
                end
            end
            // drop edges whose endpoints lie outside the node range
            S_F_RD: begin
                if (r_ei >= r_m) begin
                    n_i     = NB'(1);
                    n_state = S_I_CLR;
                end else begin
                    n_state = S_F_CHK;
                end
            end
            S_F_CHK: begin
                if (bad_edge) begin
                    n_m     = r_m - CB'(1);
                    n_state = S_F_CP_RD;
                end else begin
                    n_ei    = r_ei + CB'(1);
                    n_state = S_F_RD;
                end
            end
            S_F_CP_RD: begin
                e_raddr = r_m[EB-1:0];
                n_state = S_F_CP_WR;
            end
            S_F_CP_WR: begin
                e_we    = 1'b1;
                n_state = S_F_RD;
            end
            S_I_CLR: begin
                we_cheap = 1'b1;
                we_has   = 1'b1;
                we_pred  = 1'b1;
                we_grp   = 1'b1;
                we_mark  = 1'b1;
                if (r_i == r_n) begin
                    n_ei    = '0;
                    n_state = S_S_RD;
                end else begin
                    n_i = r_i + NB'(1);
                end
            end
            // cheapest incoming edge of each node
            S_S_RD: begin
                if (r_ei >= r_m) begin
                    n_i     = NB'(1);
                    n_state = S_C_RD;
                end else begin
                    n_state = S_S_CHK;
                end
            end
            S_S_CHK: begin
                n_t      = r_tail_q[NB-1:0];
                n_h      = r_head_q[NB-1:0];
                n_c      = r_cost_q;
                nd_raddr = r_head_q[NB-1:0];
                if (r_tail_q == r_head_q) begin
                    n_ei    = r_ei + CB'(1);
                    n_state = S_S_RD;
                end else begin
                    n_state = S_S_CMP;
                end
            end
            S_S_CMP: begin
                nd_waddr = r_h;
                if (!r_has_q || r_c < r_cheap_q) begin
                    we_cheap = 1'b1;
                    we_has   = 1'b1;
                    we_pred  = 1'b1;
                    wd_cheap = r_c;
                    wd_has   = 1'b1;
                    wd_pred  = r_t;
                end
                n_ei    = r_ei + CB'(1);
                n_state = S_S_RD;
            end
            S_C_RD: begin
                n_state = S_C_CHK;
            end
            S_C_CHK: begin
                if (r_i != r_root && !r_has_q) begin
                    n_status = ST_NO_IN;
                    n_state  = S_DONE;
                end else if (r_i == r_n) begin
                    n_state = S_R_FIX;
                end else begin
                    n_i     = r_i + NB'(1);
                    n_state = S_C_RD;
                end
            end
            S_R_FIX: begin
                nd_waddr = r_root;
                we_cheap = 1'b1;
                n_tn     = '0;
                n_i      = NB'(1);
                n_v      = NB'(1);
                n_first  = 1'b1;
                n_state  = S_W_RD;
            end
            // walk predecessors from each node to find new cycles
            S_W_RD: begin
                nd_raddr = r_v;
                n_state  = S_W_CHK;
            end
            S_W_CHK: begin
                n_first  = 1'b0;
                nd_waddr = r_v;
                if (r_first) begin
                    n_run = r_run + COST_W'(r_cheap_q);
                end
                if (walk_on) begin
                    we_mark = 1'b1;
                    wd_mark = r_i;
                    n_v     = r_pred_q;
                    n_state = S_W_RD;
                end else if (r_v != r_root && r_grp_q == '0) begin
                    n_tn    = r_tn + NB'(1);
                    we_grp  = 1'b1;
                    wd_grp  = r_tn + NB'(1);
                    n_u     = r_pred_q;
                    n_state = S_L_CHK;
                end else if (r_i == r_n) begin
                    if (r_tn == '0) begin
                        n_status = ST_OK;
                        n_state  = S_DONE;
                    end else begin
                        n_i     = NB'(1);
                        n_state = S_G_RD;
                    end
                end else begin
                    n_i     = r_i + NB'(1);
                    n_v     = r_i + NB'(1);
                    n_first = 1'b1;
                    n_state = S_W_RD;
                end
            end
            // label the rest of the cycle
            S_L_CHK: begin
                nd_raddr = r_u;
                nd_waddr = r_u;
                if (r_u == r_v) begin
                    if (r_i == r_n) begin
                        n_i     = NB'(1);
                        n_state = S_G_RD;
                    end else begin
                        n_i     = r_i + NB'(1);
                        n_v     = r_i + NB'(1);
                        n_first = 1'b1;
                        n_state = S_W_RD;
                    end
                end else begin
                    we_grp  = 1'b1;
                    wd_grp  = r_tn;
                    n_state = S_L_NXT;
                end
            end
            S_L_NXT: begin
                n_u     = r_pred_q;
                n_state = S_L_CHK;
            end
            // fresh labels for nodes outside any cycle
            S_G_RD: begin
                n_state = S_G_CHK;
            end
            S_G_CHK: begin
                if (r_grp_q == '0) begin
                    n_tn   = r_tn + NB'(1);
                    we_grp = 1'b1;
                    wd_grp = r_tn + NB'(1);
                end
                if (r_i == r_n) begin
                    n_ei    = '0;
                    n_state = S_K_RD;
                end else begin
                    n_i     = r_i + NB'(1);
                    n_state = S_G_RD;
                end
            end
            // renumber and reweight edges, drop those inside a cycle
            S_K_RD: begin
                if (r_ei >= r_m) begin
                    n_state = S_K_ROOT;
                end else begin
                    n_state = S_K_T;
                end
            end
            S_K_T: begin
                n_h      = r_head_q[NB-1:0];
                n_c      = r_cost_q;
                nd_raddr = r_tail_q[NB-1:0];
                n_state  = S_K_H;
            end
            S_K_H: begin
                n_gu     = r_grp_q;
                nd_raddr = r_h;
                n_state  = S_K_DO;
            end
            S_K_DO: begin
                if (r_gu != r_grp_q) begin
                    e_we    = 1'b1;
                    e_wtail = NW'(r_gu);
                    e_whead = NW'(r_grp_q);
                    e_wcost = r_c - r_cheap_q;
                    n_ei    = r_ei + CB'(1);
                    n_state = S_K_RD;
                end else begin
                    n_m     = r_m - CB'(1);
                    n_state = S_K_CP_RD;
                end
            end
            S_K_CP_RD: begin
                e_raddr = r_m[EB-1:0];
                n_state = S_K_CP_WR;
            end
            S_K_CP_WR: begin
                e_we    = 1'b1;
                n_state = S_K_RD;
            end
            S_K_ROOT: begin
                nd_raddr = r_root;
                n_state  = S_K_ROOT2;
            end
            S_K_ROOT2: begin
                n_root  = r_grp_q;
                n_n     = r_tn;
                n_i     = NB'(1);
                n_state = S_I_CLR;
            end
            S_DONE: begin
                n_out_valid  = 1'b1;
                n_out_status = r_status;
                n_out_cost   = (r_status == ST_OK) ? r_run : '0;
                n_etotal     = '0;
                n_ovf        = 1'b0;
                n_run        = '0;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_etotal    <= '0;
            r_ovf       <= 1'b0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_etotal    <= n_etotal;
            r_ovf       <= n_ovf;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_root       <= n_root;
        r_i          <= n_i;
        r_v          <= n_v;
        r_u          <= n_u;
        r_tn         <= n_tn;
        r_t          <= n_t;
        r_h          <= n_h;
        r_gu         <= n_gu;
        r_m          <= n_m;
        r_ei         <= n_ei;
        r_c          <= n_c;
        r_first      <= n_first;
        r_status     <= n_status;
        r_out_cost   <= n_out_cost;
        r_out_status <= n_out_status;
    end

    // edge store
    always_ff @(posedge i_clk) begin
        if (e_we) begin
            tail_mem[e_waddr] <= e_wtail;
            head_mem[e_waddr] <= e_whead;
            cost_mem[e_waddr] <= e_wcost;
        end
        r_tail_q <= tail_mem[e_raddr];
        r_head_q <= head_mem[e_raddr];
        r_cost_q <= cost_mem[e_raddr];
    end

    // per-node tables
    always_ff @(posedge i_clk) begin
        if (we_cheap) begin
            cheap_mem[nd_waddr] <= wd_cheap;
        end
        if (we_has) begin
            has_mem[nd_waddr] <= wd_has;
        end
        if (we_pred) begin
            pred_mem[nd_waddr] <= wd_pred;
        end
        if (we_grp) begin
            grp_mem[nd_waddr] <= wd_grp;
        end
        if (we_mark) begin
            mark_mem[nd_waddr] <= wd_mark;
        end
        r_cheap_q <= cheap_mem[nd_raddr];
        r_has_q   <= has_mem[nd_raddr];
        r_pred_q  <= pred_mem[nd_raddr];
        r_grp_q   <= grp_mem[nd_raddr];
        r_mark_q  <= mark_mem[nd_raddr];
    end

endmodule

[rtl/mas_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mas_checker
// port-level checks of the minimum arborescence solver
// ----------------------------------------------------------------------------
module mas_checker
    import mas_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_start,
    input logic                   o_busy,
    input logic [NODE_PORT_W-1:0] i_edge_source,
    input logic [NODE_PORT_W-1:0] i_edge_target,
    input logic [EDGE_W_PORT-1:0] i_edge_weight,
    input logic                   i_last_edge,
    input logic                   i_cfg_we,
    input logic                   i_cfg_index,
    input logic [NODE_PORT_W-1:0] i_cfg_data,
    input logic                   o_valid,
    input logic [COST_W-1:0]      o_total_cost,
    input logic [STATUS_W-1:0]    o_status
);

    // a plain edge item leaves the block idle in the next cycle and causes no result
    a_plain_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_start && !o_busy && !i_last_edge) |=> (!o_busy && !o_valid))
        else $error("plain edge item left the block busy or gave a result");

    // the last item starts a solve
    a_solve_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_start && !o_busy && i_last_edge) |=> o_busy)
        else $error("last item did not start a solve");

    // the result shows once the solve has finished
    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result shown while still solving");

    // failures carry no cost
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_total_cost == '0))
        else $error("failed solve reported a cost");

endmodule

bind min_arborescence_solver_unit mas_checker u_mas_checker (.*);

[verif/min_arborescence_solver_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_arborescence_solver_unit_tb
// Feeds directed edge lists to the solver and compares every reported
// arborescence cost and status against a cycle-contraction predictor kept
// in the bench. Graphs are mostly rooted trees plus extra edges; the rest
// is noise: self-loops, endpoints off the node range, bad roots and an
// overflowing edge store.
// ----------------------------------------------------------------------------
module min_arborescence_solver_unit_tb
    import mas_pkg::*;
;

    localparam int  N_EDGES_TARGET = 600;
    localparam int  SETTLE_CYCLES  = 40;
    localparam longint CYCLE_LIMIT = 4000000;

    typedef struct {
        logic [COST_W-1:0]   cost;
        logic [STATUS_W-1:0] status;
    } tree_result_t;

    class tree_scoreboard;
        int unsigned tail_mem [MAS_MAX_EDGES];
        int unsigned head_mem [MAS_MAX_EDGES];
        longint unsigned cost_mem [MAS_MAX_EDGES];
        int unsigned n_stored;
        bit          overflowed;
        int unsigned cfg_nodes;
        int unsigned cfg_root;
        tree_result_t expected_trees [$];
        int unsigned errors;
        int unsigned n_checked;
        int unsigned n_by_status [4];

        function new();
            n_stored   = 0;
            overflowed = 0;
            cfg_nodes  = MAS_MAX_NODES;
            cfg_root   = 1;
            errors     = 0;
            n_checked  = 0;
            foreach (n_by_status[k]) n_by_status[k] = 0;
        endfunction

        function void write_reg(logic idx, logic [NODE_PORT_W-1:0] val);
            if (idx == CFG_NODE_COUNT) cfg_nodes = val;
            else cfg_root = val;
        endfunction

        function void drop(int unsigned i, int unsigned j);
            tail_mem[i] = tail_mem[j];
            head_mem[i] = head_mem[j];
            cost_mem[i] = cost_mem[j];
        endfunction

        // cycle contraction; total cost in acc
        function logic [STATUS_W-1:0] contract(output longint unsigned acc);
            int unsigned n, root, m, i, u, v, tn, old_head;
            longint unsigned best [MAS_MAX_NODES+1];
            bit has_in [MAS_MAX_NODES+1];
            int unsigned pred [MAS_MAX_NODES+1];
            int unsigned grp [MAS_MAX_NODES+1];
            int unsigned mark [MAS_MAX_NODES+1];
            acc  = 0;
            n    = cfg_nodes;
            root = cfg_root;
            m    = n_stored;
            if (overflowed) return ST_OVERFLOW;
            if (n < 1) n = 1;
            if (n > MAS_MAX_NODES) n = MAS_MAX_NODES;
            if (root < 1 || root > n) return ST_NO_IN;
            i = 0;
            while (i < m) begin
                u = tail_mem[i];
                v = head_mem[i];
                if (u < 1 || u > n || v < 1 || v > n) begin
                    m--;
                    drop(i, m);
                end else begin
                    i++;
                end
            end
            forever begin
                for (i = 1; i <= n; i++) begin
                    has_in[i] = 0; best[i] = 0; pred[i] = 0; grp[i] = 0; mark[i] = 0;
                end
                for (i = 0; i < m; i++) begin
                    u = tail_mem[i];
                    v = head_mem[i];
                    if (u != v && (!has_in[v] || cost_mem[i] < best[v])) begin
                        has_in[v] = 1;
                        best[v]   = cost_mem[i];
                        pred[v]   = u;
                    end
                end
                for (i = 1; i <= n; i++)
                    if (i != root && !has_in[i]) begin
                        acc = 0;
                        return ST_NO_IN;
                    end
                best[root] = 0;
                tn = 0;
                for (i = 1; i <= n; i++) begin
                    acc = (acc + best[i]) & 64'hFF_FFFF_FFFF;
                    v = i;
                    while (mark[v] != i && grp[v] == 0 && v != root) begin
                        mark[v] = i;
                        v = pred[v];
                    end
                    if (v != root && grp[v] == 0) begin
                        tn++;
                        grp[v] = tn;
                        for (u = pred[v]; u != v; u = pred[u]) grp[u] = tn;
                    end
                end
                if (tn == 0) break;
                for (i = 1; i <= n; i++)
                    if (grp[i] == 0) grp[i] = ++tn;
                i = 0;
                while (i < m) begin
                    old_head = head_mem[i];
                    u = grp[tail_mem[i]];
                    v = grp[old_head];
                    if (u != v) begin
                        tail_mem[i] = u;
                        head_mem[i] = v;
                        cost_mem[i] -= best[old_head];
                        i++;
                    end else begin
                        m--;
                        drop(i, m);
                    end
                end
                n    = tn;
                root = grp[root];
            end
            return ST_OK;
        endfunction

        function void note_edge(logic [NODE_PORT_W-1:0] src, logic [NODE_PORT_W-1:0] dst,
                                logic [EDGE_W_PORT-1:0] w, logic last);
            tree_result_t r;
            longint unsigned acc;
            if (src != dst) begin
                if (n_stored >= MAS_MAX_EDGES) begin
                    overflowed = 1;
                end else begin
                    tail_mem[n_stored] = src;
                    head_mem[n_stored] = dst;
                    cost_mem[n_stored] = w;
                    n_stored++;
                end
            end
            if (last) begin
                r.status = contract(acc);
                r.cost   = (r.status == ST_OK) ? acc[COST_W-1:0] : '0;
                expected_trees.push_back(r);
                n_stored   = 0;
                overflowed = 0;
            end
        endfunction

        function void check_tree(logic [COST_W-1:0] cost, logic [STATUS_W-1:0] status);
            tree_result_t r;
            if (expected_trees.size() == 0) begin
                $error("result with none expected: total_cost %0d status %0d", cost, status);
                errors++;
                return;
            end
            r = expected_trees.pop_front();
            n_checked++;
            n_by_status[r.status]++;
            if (cost !== r.cost) begin
                $error("total_cost: expected %0d, actual %0d", r.cost, cost);
                errors++;
            end
            if (status !== r.status) begin
                $error("status: expected %0d, actual %0d", r.status, status);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_start = 1'b0;
    logic                   o_busy;
    logic [NODE_PORT_W-1:0] i_edge_source = '0;
    logic [NODE_PORT_W-1:0] i_edge_target = '0;
    logic [EDGE_W_PORT-1:0] i_edge_weight = '0;
    logic                   i_last_edge = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic                   i_cfg_index = 1'b0;
    logic [NODE_PORT_W-1:0] i_cfg_data = '0;
    logic                   o_valid;
    logic [COST_W-1:0]      o_total_cost;
    logic [STATUS_W-1:0]    o_status;

    tree_scoreboard sb = new();
    longint cycle_count = 0;
    int unsigned edges_sent = 0;
    int unsigned burst_left = 0;

    min_arborescence_solver_unit i_dut (.*);

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("min_arborescence_solver_unit_tb: done, errors");
            $finish;
        end
    end

    // results last one cycle; sample mid-cycle
    always @(negedge i_clk)
        if (i_rst_n && o_valid) sb.check_tree(o_total_cost, o_status);

    // called in a posedge step; returns in the posedge step of acceptance or later
    task automatic send_edge(input logic [NODE_PORT_W-1:0] src,
                             input logic [NODE_PORT_W-1:0] dst,
                             input logic [EDGE_W_PORT-1:0] w, input logic last);
        i_start       <= 1'b1;
        i_edge_source <= src;
        i_edge_target <= dst;
        i_edge_weight <= w;
        i_last_edge   <= last;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_edge(src, dst, w, last);
        edges_sent++;
        // start must drop after the last item or it would be taken twice
        if (last || burst_left == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(0, 10);
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        while (sb.expected_trees.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [NODE_PORT_W-1:0] val);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [EDGE_W_PORT-1:0] pick_weight();
        case ($urandom_range(0, 9))
            0:       return '1;
            1, 2:    return EDGE_W_PORT'($urandom());
            default: return EDGE_W_PORT'($urandom_range(0, 20));
        endcase
    endfunction

    // rooted tree plus extra edges in shuffled order, with some noise edges
    task automatic send_graph(input int unsigned n, input int unsigned root);
        int unsigned order [$];
        int unsigned perm [$];
        int unsigned k, j, extra, tmp;
        logic [NODE_PORT_W-1:0] s_q [$];
        logic [NODE_PORT_W-1:0] d_q [$];
        for (k = 1; k <= n; k++) if (k != root) perm.push_back(k);
        perm.shuffle();
        perm.push_front(root);
        for (k = 1; k < perm.size(); k++) begin
            // occasionally leave a node without an edge into it
            if ($urandom_range(0, 29) != 0) begin
                s_q.push_back(NODE_PORT_W'(perm[$urandom_range(0, k - 1)]));
                d_q.push_back(NODE_PORT_W'(perm[k]));
            end
        end
        extra = $urandom_range(0, 2 * n);
        for (k = 0; k < extra; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                s_q.push_back(NODE_PORT_W'($urandom_range(0, 127)));
                d_q.push_back(NODE_PORT_W'($urandom_range(0, 127)));
            end else begin
                s_q.push_back(NODE_PORT_W'($urandom_range(1, n)));
                d_q.push_back(NODE_PORT_W'($urandom_range(1, n)));
            end
        end
        if (s_q.size() == 0) begin
            s_q.push_back(NODE_PORT_W'(root));
            d_q.push_back(NODE_PORT_W'(root));
        end
        for (k = 0; k < s_q.size(); k++) order.push_back(k);
        order.shuffle();
        for (k = 0; k < order.size(); k++) begin
            j = order[k];
            send_edge(s_q[j], d_q[j], pick_weight(), k == order.size() - 1);
        end
    endtask

    initial begin
        int unsigned n, root, k;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: 64 nodes, one edge, so most nodes have nothing coming in
        send_edge(7'd1, 7'd2, 24'd9, 1'b1);
        write_reg(CFG_NODE_COUNT, 7'd3);
        // two-node cycle to contract, self-loop, endpoints off the range
        send_edge(7'd1, 7'd2, 24'd5, 1'b0);
        send_edge(7'd2, 7'd3, 24'hFF_FFFF, 1'b0);
        send_edge(7'd3, 7'd2, 24'd1, 1'b0);
        send_edge(7'd2, 7'd2, 24'd0, 1'b0);
        send_edge(7'd0, 7'd3, 24'd0, 1'b0);
        send_edge(7'd127, 7'd2, 24'd0, 1'b0);
        send_edge(7'd3, 7'd1, 24'd0, 1'b1);
        // root off the range at both ends
        write_reg(CFG_ROOT_NODE, 7'd0);
        send_edge(7'd1, 7'd2, 24'd3, 1'b1);
        write_reg(CFG_ROOT_NODE, 7'd127);
        send_edge(7'd1, 7'd2, 24'd3, 1'b1);
        // node count zero means one node; a lone self-loop still solves
        write_reg(CFG_ROOT_NODE, 7'd1);
        write_reg(CFG_NODE_COUNT, 7'd0);
        send_edge(7'd1, 7'd1, 24'hFF_FFFF, 1'b1);
        // node count above range saturates, root at the top node
        write_reg(CFG_NODE_COUNT, 7'd127);
        write_reg(CFG_ROOT_NODE, 7'd64);
        send_edge(7'd64, 7'd1, 24'hFF_FFFF, 1'b1);
        write_reg(CFG_NODE_COUNT, 7'd64);
        send_graph(64, 64);

        // edge store overflow on a small graph
        write_reg(CFG_NODE_COUNT, 7'd2);
        write_reg(CFG_ROOT_NODE, 7'd1);
        for (k = 0; k < MAS_MAX_EDGES + 4; k++)
            send_edge(7'd1, 7'd2, EDGE_W_PORT'($urandom()), k == MAS_MAX_EDGES + 3);
        send_edge(7'd1, 7'd2, 24'd4, 1'b1);

        k = edges_sent;
        while (edges_sent - k < N_EDGES_TARGET) begin
            case ($urandom_range(0, 19))
                0:       n = 64;
                1, 2, 3: n = $urandom_range(9, 20);
                default: n = $urandom_range(2, 8);
            endcase
            root = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                : $urandom_range(1, n);
            if (sb.cfg_nodes != n) write_reg(CFG_NODE_COUNT, NODE_PORT_W'(n));
            if (sb.cfg_root != root) write_reg(CFG_ROOT_NODE, NODE_PORT_W'(root));
            send_graph(n, (root >= 1 && root <= n) ? root : 1);
        end

        wait_idle();
        $display("covered %0d edges, %0d graphs solved (ok %0d, no in-edge %0d, overflow %0d)",
                 edges_sent, sb.n_checked, sb.n_by_status[ST_OK],
                 sb.n_by_status[ST_NO_IN], sb.n_by_status[ST_OVERFLOW]);
        if (sb.errors == 0 && sb.expected_trees.size() == 0)
            $display("min_arborescence_solver_unit_tb: done, clean");
        else
            $display("min_arborescence_solver_unit_tb: done, errors");
        $finish;
    end

endmodule

[files.f]
rtl/mas_pkg.sv
rtl/min_arborescence_solver_unit.sv
rtl/mas_checker.sv
verif/min_arborescence_solver_unit_tb.sv
